@@ rtl/sed_pkg.sv @@
package sed_pkg;

	// Error codes carried on the closing result
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_DANGLING = 2'd1;
	localparam logic [1:0] ERR_BAD_UNI  = 2'd2;

	// UTF-8 range limits and lead/continuation marks
	localparam logic [31:0] UTF8_LIM1 = 32'h0000_007F;
	localparam logic [31:0] UTF8_LIM2 = 32'h0000_07FF;
	localparam logic [31:0] UTF8_LIM3 = 32'h0000_FFFF;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;
	localparam logic [7:0]  UTF8_MASK  = 8'h3F;

	// One queued burst: up to four data bytes, then an optional closing result
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      nbyte;
		logic            close;
		logic [1:0]      err;
	} sed_cmd_t;

	typedef struct packed {
		logic            ok;
		logic [3:0]      val;
	} sed_hex_t;

	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      nbyte;
	} sed_utf8_t;

	function automatic sed_hex_t hex_digit(input logic [7:0] c);
		sed_hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= "0" && c <= "9") begin
			h.val = 4'(c - 8'h30);
		end else if (c >= "a" && c <= "f") begin
			h.val = 4'(c - 8'h57);
		end else if (c >= "A" && c <= "F") begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic sed_utf8_t utf8_encode(input logic [31:0] v);
		sed_utf8_t u;
		u.data = '0;
		if (v <= UTF8_LIM1) begin
			u.nbyte   = 3'd1;
			u.data[0] = v[7:0];
		end else if (v <= UTF8_LIM2) begin
			u.nbyte   = 3'd2;
			u.data[0] = UTF8_LEAD2 | {3'b000, v[10:6]};
			u.data[1] = UTF8_CONT | ({2'b00, v[5:0]} & UTF8_MASK);
		end else if (v <= UTF8_LIM3) begin
			u.nbyte   = 3'd3;
			u.data[0] = UTF8_LEAD3 | {4'b0000, v[15:12]};
			u.data[1] = UTF8_CONT | ({2'b00, v[11:6]} & UTF8_MASK);
			u.data[2] = UTF8_CONT | ({2'b00, v[5:0]} & UTF8_MASK);
		end else begin
			u.nbyte   = 3'd4;
			u.data[0] = UTF8_LEAD4 | v[25:18];
			u.data[1] = UTF8_CONT | ({2'b00, v[17:12]} & UTF8_MASK);
			u.data[2] = UTF8_CONT | ({2'b00, v[11:6]} & UTF8_MASK);
			u.data[3] = UTF8_CONT | ({2'b00, v[5:0]} & UTF8_MASK);
		end
		return u;
	endfunction

endpackage

@@ rtl/sed_in_if.sv @@
interface sed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_end;

	modport source (output valid, output in_byte, output is_end, input ready);
	modport sink (input valid, input in_byte, input is_end, output ready);
endinterface

@@ rtl/sed_out_if.sv @@
interface sed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic [1:0] error_code;
	logic       literal_done;
	logic       last_of_run;

	modport source (output valid, output out_byte, output has_byte, output error_code,
		output literal_done, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input has_byte, input error_code,
		input literal_done, input last_of_run, output ready);
endinterface

@@ rtl/sed_front.sv @@
module sed_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        in_byte,
	input  logic              is_end,
	output logic              push,
	output sed_pkg::sed_cmd_t cmd
);
	import sed_pkg::*;

	localparam logic [2:0] MODE_NORMAL = 3'd0;
	localparam logic [2:0] MODE_ESCAPE = 3'd1;
	localparam logic [2:0] MODE_HEX    = 3'd2;
	localparam logic [2:0] MODE_UNI    = 3'd3;
	localparam logic [2:0] MODE_DROP   = 3'd4;

	logic [2:0]  mode_q, mode_d;
	logic [31:0] acc_q, acc_d;
	logic [3:0]  left_q, left_d;
	logic [1:0]  err_q, err_d;

	sed_hex_t    hv;
	logic [31:0] acc_sh;
	sed_utf8_t   u8;

	assign hv     = hex_digit(in_byte);
	assign acc_sh = {acc_q[27:0], hv.val};
	assign u8     = utf8_encode(acc_sh);

	// Classify the byte against the current mode and build the burst
	always_comb begin
		mode_d    = mode_q;
		acc_d     = acc_q;
		left_d    = left_q;
		err_d     = err_q;
		cmd       = '0;
		cmd.err   = ERR_NONE;
		if (is_end) begin
			cmd.close = 1'b1;
			case (mode_q)
				MODE_HEX: begin
					cmd.nbyte   = 3'd1;
					cmd.data[0] = acc_q[7:0];
				end
				MODE_ESCAPE: cmd.err = ERR_DANGLING;
				MODE_UNI:    cmd.err = ERR_BAD_UNI;
				MODE_DROP:   cmd.err = err_q;
				default:     cmd.err = ERR_NONE;
			endcase
			mode_d = MODE_NORMAL;
			acc_d  = '0;
			left_d = '0;
			err_d  = ERR_NONE;
		end else begin
			case (mode_q)
				MODE_ESCAPE: begin
					mode_d      = MODE_NORMAL;
					cmd.nbyte   = 3'd1;
					cmd.data[0] = in_byte;
					case (in_byte)
						"n": cmd.data[0] = 8'h0A;
						"t": cmd.data[0] = 8'h09;
						"r": cmd.data[0] = 8'h0D;
						"b": cmd.data[0] = 8'h08;
						"a": cmd.data[0] = 8'h07;
						"f": cmd.data[0] = 8'h0C;
						"v": cmd.data[0] = 8'h0B;
						"0": cmd.data[0] = 8'h00;
						"x": begin
							mode_d    = MODE_HEX;
							acc_d     = '0;
							cmd.nbyte = 3'd0;
						end
						"u": begin
							mode_d    = MODE_UNI;
							acc_d     = '0;
							left_d    = 4'd4;
							cmd.nbyte = 3'd0;
						end
						"U": begin
							mode_d    = MODE_UNI;
							acc_d     = '0;
							left_d    = 4'd8;
							cmd.nbyte = 3'd0;
						end
						default: cmd.data[0] = in_byte;
					endcase
				end
				MODE_HEX: begin
					if (hv.ok) begin
						acc_d = acc_sh;
					end else begin
						// value byte first, then the byte as plain text
						cmd.data[0] = acc_q[7:0];
						if (in_byte == "\\") begin
							mode_d    = MODE_ESCAPE;
							cmd.nbyte = 3'd1;
						end else begin
							mode_d      = MODE_NORMAL;
							cmd.nbyte   = 3'd2;
							cmd.data[1] = in_byte;
						end
					end
				end
				MODE_UNI: begin
					if (!hv.ok) begin
						err_d  = ERR_BAD_UNI;
						mode_d = MODE_DROP;
					end else begin
						acc_d  = acc_sh;
						left_d = left_q - 4'd1;
						if (left_q == 4'd1) begin
							cmd.data  = u8.data;
							cmd.nbyte = u8.nbyte;
							mode_d    = MODE_NORMAL;
							acc_d     = '0;
						end
					end
				end
				MODE_DROP: mode_d = MODE_DROP;
				default: begin
					if (in_byte == "\\") begin
						mode_d = MODE_ESCAPE;
					end else begin
						mode_d      = MODE_NORMAL;
						cmd.nbyte   = 3'd1;
						cmd.data[0] = in_byte;
					end
				end
			endcase
		end
	end

	assign push = take && (cmd.close || cmd.nbyte != 3'd0);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			acc_q  <= '0;
			left_q <= '0;
			err_q  <= ERR_NONE;
		end else if (take) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			left_q <= left_d;
			err_q  <= err_d;
		end
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_end |=> mode_q == MODE_NORMAL && err_q == ERR_NONE)
		else $error("end of literal did not return decoder to normal text");

endmodule

@@ rtl/sed_queue.sv @@
module sed_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sed_pkg::sed_cmd_t push_data,
	input  logic              pop,
	output sed_pkg::sed_cmd_t pop_data,
	output logic              full,
	output logic              empty
);
	import sed_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sed_cmd_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full     = count_q == FULL_CNT;
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |=> full && $stable(wr_ptr_q))
		else $error("queue written while full");

endmodule

@@ rtl/sed_back.sv @@
module sed_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  sed_pkg::sed_cmd_t head,
	output logic              pop,
	sed_out_if.source         results
);
	import sed_pkg::*;

	sed_cmd_t   cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic [2:0] total;
	logic       last;
	logic       is_data;

	assign total   = cur_q.nbyte + {2'b00, cur_q.close};
	assign last    = ({1'b0, idx_q} + 3'd1) == total;
	assign is_data = {1'b0, idx_q} < cur_q.nbyte;

	// Result fields for the current position in the burst
	assign results.valid        = busy_q;
	assign results.out_byte     = is_data ? cur_q.data[idx_q] : 8'h00;
	assign results.has_byte     = is_data;
	assign results.error_code   = is_data ? ERR_NONE : cur_q.err;
	assign results.literal_done = !is_data;
	assign results.last_of_run  = last;

	assign pop = !empty && (!busy_q || (results.ready && last));

	// Busy flag and position within the burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && results.ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	a_err_only_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && results.error_code != ERR_NONE |-> results.literal_done)
		else $error("error code outside the closing result");

	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && results.literal_done |-> results.last_of_run && !results.has_byte)
		else $error("closing result is not the last of its burst");

endmodule

@@ rtl/string_escape_to_utf8_decoder.sv @@
// String literal escape decoder, UTF-8 output.
// chars (sink): one raw byte of a literal body per transaction, or an end
//   item (is_end = 1) that closes the literal.
// results (source): decoded bytes, then one closing result per end item with
//   literal_done set, has_byte clear and error_code (dangling backslash or bad
//   universal escape). last_of_run marks the final result of each input item.
// Path: with the output idle, an accepted item is written into the command
//   queue and then loaded into the output stage's burst register, after
//   which results.valid rises. An item that yields no result (a backslash,
//   a hex digit, a byte in drop mode) leaves nothing on the output.
// Throughput: one input item per cycle while the command queue is not full,
//   one result out per cycle while results.ready is 1. An item with several
//   results (\u, \U, closing bursts) holds the output until all are taken.
//   The command queue (QUEUE_DEPTH bursts) links decoder and output stage.
// Reset: the decoder returns to plain text with no held error, the queue and
//   the output stage empty.
// Stalls: with results.ready low the output holds its transaction; chars.ready
//   drops only once the command queue is full.
module string_escape_to_utf8_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	sed_in_if.sink     chars,
	sed_out_if.source  results
);
	import sed_pkg::*;

	sed_cmd_t cmd, head;
	logic     push, pop, full, empty, take;

	assign chars.ready = !full;
	assign take        = chars.valid && !full;

	sed_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (chars.in_byte),
		.is_end  (chars.is_end),
		.push    (push),
		.cmd     (cmd)
	);

	sed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.pop_data  (head),
		.full      (full),
		.empty     (empty)
	);

	sed_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule

@@ bench/string_escape_to_utf8_decoder_tb.sv @@
module string_escape_to_utf8_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sed_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 25;
	localparam int SQUEEZE_HOLD = 150;

	// Decoder modes as the predictor tracks them
	typedef enum logic [2:0] {
		LIT_TEXT,
		LIT_ESCAPE,
		LIT_HEX,
		LIT_UNIVERSAL,
		LIT_DROP
	} lit_mode_e;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [1:0] error_code;
		logic       literal_done;
		logic       last_of_run;
	} sed_result_t;

	// Predicts the decoded bytes of each accepted character and checks them in order
	class escape_scoreboard;
		lit_mode_e   mode;
		logic [31:0] acc;
		logic [3:0]  digits_left;
		logic [1:0]  held_err;
		sed_result_t expected_q[$];
		sed_result_t burst[$];
		int          mismatches;

		function new();
			clear_state();
			mismatches = 0;
		endfunction

		function void clear_state();
			mode        = LIT_TEXT;
			acc         = '0;
			digits_left = '0;
			held_err    = ERR_NONE;
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c - "0");
			if (c >= "a" && c <= "f") return int'(c - "a") + 10;
			if (c >= "A" && c <= "F") return int'(c - "A") + 10;
			return -1;
		endfunction

		function void emit(logic [7:0] b, logic has, logic [1:0] err, logic done);
			sed_result_t r;
			r.out_byte     = b;
			r.has_byte     = has;
			r.error_code   = err;
			r.literal_done = done;
			r.last_of_run  = 1'b0;
			burst.push_back(r);
		endfunction

		function void text_byte(logic [7:0] c);
			if (c == "\\") begin
				mode = LIT_ESCAPE;
			end else begin
				emit(c, 1'b1, ERR_NONE, 1'b0);
			end
		endfunction

		function void escape_char(logic [7:0] c);
			logic [7:0] r;
			r    = c;
			mode = LIT_TEXT;
			case (c)
				"n": r = 8'h0A;
				"t": r = 8'h09;
				"r": r = 8'h0D;
				"b": r = 8'h08;
				"a": r = 8'h07;
				"f": r = 8'h0C;
				"v": r = 8'h0B;
				"0": r = 8'h00;
				"x": begin
					mode = LIT_HEX;
					acc  = '0;
					return;
				end
				"u", "U": begin
					mode        = LIT_UNIVERSAL;
					acc         = '0;
					digits_left = (c == "u") ? 4'd4 : 4'd8;
					return;
				end
				default: ;
			endcase
			emit(r, 1'b1, ERR_NONE, 1'b0);
		endfunction

		function void utf8(logic [31:0] v);
			logic [31:0] lead;
			if (v <= UTF8_LIM1) begin
				emit(v[7:0], 1'b1, ERR_NONE, 1'b0);
			end else if (v <= UTF8_LIM2) begin
				lead = 32'(UTF8_LEAD2) | (v >> 6);
				emit(lead[7:0], 1'b1, ERR_NONE, 1'b0);
				emit(UTF8_CONT | {2'b00, v[5:0]}, 1'b1, ERR_NONE, 1'b0);
			end else if (v <= UTF8_LIM3) begin
				lead = 32'(UTF8_LEAD3) | (v >> 12);
				emit(lead[7:0], 1'b1, ERR_NONE, 1'b0);
				emit(UTF8_CONT | {2'b00, v[11:6]}, 1'b1, ERR_NONE, 1'b0);
				emit(UTF8_CONT | {2'b00, v[5:0]}, 1'b1, ERR_NONE, 1'b0);
			end else begin
				// no range check: high bits spill into the lead byte
				lead = 32'(UTF8_LEAD4) | (v >> 18);
				emit(lead[7:0], 1'b1, ERR_NONE, 1'b0);
				emit(UTF8_CONT | {2'b00, v[17:12]}, 1'b1, ERR_NONE, 1'b0);
				emit(UTF8_CONT | {2'b00, v[11:6]}, 1'b1, ERR_NONE, 1'b0);
				emit(UTF8_CONT | {2'b00, v[5:0]}, 1'b1, ERR_NONE, 1'b0);
			end
		endfunction

		// Returns 1 unless the character was silently dropped
		function bit note_char(logic [7:0] c, logic is_end);
			int         h;
			bit         dropped;
			logic [1:0] err;
			burst.delete();
			dropped = !is_end && mode == LIT_DROP;
			if (is_end) begin
				err = ERR_NONE;
				case (mode)
					LIT_HEX:       emit(acc[7:0], 1'b1, ERR_NONE, 1'b0);
					LIT_ESCAPE:    err = ERR_DANGLING;
					LIT_UNIVERSAL: err = ERR_BAD_UNI;
					LIT_DROP:      err = held_err;
					default: ;
				endcase
				emit(8'h00, 1'b0, err, 1'b1);
				clear_state();
			end else begin
				case (mode)
					LIT_ESCAPE: escape_char(c);
					LIT_HEX: begin
						h = hex_nibble(c);
						if (h >= 0) begin
							acc = {acc[27:0], 4'(h)};
						end else begin
							// non-hex byte closes the escape, then counts as text
							emit(acc[7:0], 1'b1, ERR_NONE, 1'b0);
							mode = LIT_TEXT;
							text_byte(c);
						end
					end
					LIT_UNIVERSAL: begin
						h = hex_nibble(c);
						if (h < 0) begin
							held_err = ERR_BAD_UNI;
							mode     = LIT_DROP;
						end else begin
							acc         = {acc[27:0], 4'(h)};
							digits_left = digits_left - 4'd1;
							if (digits_left == 4'd0) begin
								utf8(acc);
								mode = LIT_TEXT;
								acc  = '0;
							end
						end
					end
					LIT_DROP: ;
					default: begin
						mode = LIT_TEXT;
						text_byte(c);
					end
				endcase
			end
			if (burst.size() > 0) burst[burst.size() - 1].last_of_run = 1'b1;
			foreach (burst[i]) expected_q.push_back(burst[i]);
			return !dropped;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
			mismatches++;
		endtask

		task check_result(sed_result_t got);
			sed_result_t want;
			if (expected_q.size() == 0) begin
				report("result with nothing pending", 32'(got), 32'd0);
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte)
				report("out_byte", 32'(got.out_byte), 32'(want.out_byte));
			if (got.has_byte !== want.has_byte)
				report("has_byte", 32'(got.has_byte), 32'(want.has_byte));
			if (got.error_code !== want.error_code)
				report("error_code", 32'(got.error_code), 32'(want.error_code));
			if (got.literal_done !== want.literal_done)
				report("literal_done", 32'(got.literal_done), 32'(want.literal_done));
			if (got.last_of_run !== want.last_of_run)
				report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sed_in_if  chars ();
	sed_out_if results ();

	string_escape_to_utf8_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.results (results)
	);

	escape_scoreboard ledger;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	int               items_sent = 0;
	int               cycles = 0;
	int               hold_token = 0;
	int               hold_seen = 0;
	int               hold_left = 0;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: check each transaction, then choose ready for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (results.valid && results.ready) begin
				ledger.check_result({results.out_byte, results.has_byte, results.error_code,
					results.literal_done, results.last_of_run});
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = SQUEEZE_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else begin
				results.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one character transaction and wait until it is taken
	task automatic put_char(input logic [7:0] c, input logic is_end);
		while ($urandom_range(99) < send_idle_pct) begin
			chars.valid <= 1'b0;
			@(posedge clk);
		end
		chars.valid   <= 1'b1;
		chars.in_byte <= c;
		chars.is_end  <= is_end;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
		if (ledger.note_char(c, is_end)) items_sent++;
	endtask

	task automatic wait_drained();
		chars.valid <= 1'b0;
		do @(posedge clk); while (ledger.expected_q.size() > 0);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
		if (n < 4'd10) return 8'("0") + 8'(n);
		return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
	endfunction

	task automatic put_digits(input logic [31:0] v, input int count);
		for (int i = count - 1; i >= 0; i--) put_char(hex_char(v[i*4 +: 4], $urandom_range(1)), 1'b0);
	endtask

	function automatic logic [31:0] random_code(int bucket);
		case (bucket)
			0:       return $urandom_range(32'h7F, 0);
			1:       return $urandom_range(32'h7FF, 32'h80);
			2:       return $urandom_range(32'hFFFF, 32'h800);
			3:       return $urandom_range(32'h1FFFFF, 32'h10000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (ledger.hex_nibble(c) >= 0);
		return c;
	endfunction

	// One literal built from plain bytes and well-formed escapes, with some broken ones
	task automatic random_literal();
		logic [7:0] simple_set[12];
		logic [7:0] c;
		bit         wide;
		int         segs;
		simple_set = '{"\\", "'", "\"", "n", "t", "r", "b", "a", "f", "v", "0", 8'h00};
		segs = $urandom_range(6, 1);
		repeat (segs) begin
			case ($urandom_range(9))
				0, 1, 9: put_char(8'($urandom_range(255)), 1'b0);
				2: begin
					c = simple_set[$urandom_range(11)];
					if (c == 8'h00) c = 8'($urandom_range(255));
					put_char("\\", 1'b0);
					put_char(c, 1'b0);
				end
				3: begin
					put_char("\\", 1'b0);
					put_char("x", 1'b0);
					put_digits($urandom, $urandom_range(8));
					// now and then more digits than fit in 32 bits
					if ($urandom_range(3) == 0) put_digits($urandom, 3);
				end
				4: begin
					put_char("\\", 1'b0);
					put_char("u", 1'b0);
					put_digits(random_code($urandom_range(2)), 4);
				end
				5: begin
					put_char("\\", 1'b0);
					put_char("U", 1'b0);
					put_digits(random_code($urandom_range(4)), 8);
				end
				6: begin
					// bad digit inside a universal escape, then dropped bytes
					wide = $urandom_range(1);
					put_char("\\", 1'b0);
					put_char(wide ? "U" : "u", 1'b0);
					put_digits($urandom, $urandom_range(wide ? 7 : 3));
					put_char(non_hex_byte(), 1'b0);
					repeat ($urandom_range(3)) put_char(8'($urandom_range(255)), 1'b0);
				end
				7: begin
					put_char("\\", 1'b0);
					break;
				end
				8: begin
					// literal closed before the universal escape is complete
					put_char("\\", 1'b0);
					put_char("u", 1'b0);
					put_digits($urandom, $urandom_range(3));
					break;
				end
			endcase
		end
		put_char(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		ledger        = new();
		arst_n        = 1'b0;
		chars.valid   = 1'b0;
		chars.in_byte = 8'h00;
		chars.is_end  = 1'b0;
		results.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: byte extremes, hex escape ends, large \U, dangling and bad escapes
		put_char(8'h00, 1'b0);
		put_char(8'hFF, 1'b0);
		put_char("\\", 1'b0);
		put_char("x", 1'b0);
		put_char("G", 1'b0);
		put_char("\\", 1'b0);
		put_char("x", 1'b0);
		put_char("4", 1'b0);
		put_char("1", 1'b0);
		put_char(8'hFF, 1'b1);
		put_char("\\", 1'b0);
		put_char("U", 1'b0);
		put_digits(32'hFFFF_FFFF, 8);
		put_char(8'h00, 1'b1);
		put_char("\\", 1'b0);
		put_char(8'h00, 1'b1);
		put_char("\\", 1'b0);
		put_char("u", 1'b0);
		put_char("Z", 1'b0);
		put_char("q", 1'b0);
		put_char(8'h00, 1'b1);

		// Squeeze: drain, then hold results back while characters keep coming
		wait_drained();
		@(negedge clk) hold_token++;
		@(posedge clk);
		items_sent = 0;
		while (items_sent < 30) random_literal();
		wait_drained();

		// Random literals under each idling mix
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 62; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 62; end
				default: begin send_idle_pct = 21; stall_pct = 21; end
			endcase
			items_sent = 0;
			while (items_sent < PHASE_ITEMS) random_literal();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
